[sv/slfp_pkg.sv]
// Package for the scan line fade pattern block.
// Shared types, widths, register indexes and fixed constants; no dependencies.
`default_nettype none
package slfp_pkg;

	localparam int COORD_W    = 3;
	localparam int LEVEL_W    = 9;
	localparam int HUE_W      = 9;
	localparam int COLOR_W    = 24;
	localparam int POS_W      = 16;
	localparam int SPEED_W    = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 1;

	// Brightness scale: 256 is full, fade multiplies by 230/256
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 9'd256;
	localparam logic [7:0]         FADE_MUL   = 8'd230;
	localparam logic [LEVEL_W-1:0] FADE_FLOOR = 9'd3;

	// Register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_LINE_SPEED    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_COLUMNS = 1'd1;
	localparam logic [SPEED_W-1:0]   SPEED_RESET       = 12'd128;
	localparam logic [COLOR_W-1:0]   COLOR_RESET       = 24'hFF0000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COLOR,
		ST_WALK
	} slfp_state_t;

	// Control from the sequencer to the cell chain and pixel stage
	typedef struct packed {
		logic               step;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
		logic               on_line;
	} slfp_head_ctl_t;

endpackage
`default_nettype wire

[sv/slfp_cell.sv]
// One cell of the circulating brightness chain.
// Uses slfp_pkg for the level width.
`default_nettype none
module slfp_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        shift,
	input  wire logic [slfp_pkg::LEVEL_W-1:0] level_in,
	output logic      [slfp_pkg::LEVEL_W-1:0] level_out
);
	import slfp_pkg::*;

	logic [LEVEL_W-1:0] level_q;

	// take the neighbor's level on every step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (shift) begin
			level_q <= level_in;
		end
	end

	assign level_out = level_q;

endmodule
`default_nettype wire

[sv/slfp_line_ctrl.sv]
// Sequencer: config registers, line position and direction, line color,
// frame walk counters. Uses slfp_pkg.
`default_nettype none
module slfp_line_ctrl #(
	parameter int GRID_WIDTH  = 8,
	parameter int GRID_HEIGHT = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [slfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [slfp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [slfp_pkg::HUE_W-1:0]      new_hue,
	input  wire logic                           pipe_empty,
	input  wire logic                           step_ok,
	output slfp_pkg::slfp_head_ctl_t             ctl,
	output logic      [slfp_pkg::COLOR_W-1:0]    line_color
);
	import slfp_pkg::*;

	localparam logic signed [POS_W+1:0] EDGE_W_FIX = (POS_W+2)'(GRID_WIDTH * 256);
	localparam logic signed [POS_W+1:0] EDGE_H_FIX = (POS_W+2)'(GRID_HEIGHT * 256);
	localparam logic [COORD_W-1:0] X_LAST = COORD_W'(GRID_WIDTH - 1);
	localparam logic [COORD_W-1:0] Y_LAST = COORD_W'(GRID_HEIGHT - 1);

	// hue in degrees to full-saturation RGB888
	function automatic logic [COLOR_W-1:0] hue_to_rgb(input logic [HUE_W-1:0] hue);
		logic [3:0] seg;
		logic [HUE_W-1:0] rem;
		logic [9:0] qx;
		logic [9:0] tx;
		logic [7:0] q;
		logic [7:0] t;
		logic [COLOR_W-1:0] rgb;
		seg = '0;
		for (int k = 1; k <= 8; k++) begin
			if (hue >= HUE_W'(60 * k)) seg = seg + 4'd1;
		end
		rem = hue - HUE_W'(seg) * 9'd60;
		// 255/60 = 17/4
		qx = (10'(9'd60 - rem) << 4) + 10'(9'd60 - rem);
		tx = (10'(rem) << 4) + 10'(rem);
		q = qx[9:2];
		t = tx[9:2];
		case (seg) inside
			4'd0, 4'd6: rgb = {8'hFF, t, 8'h00};
			4'd1, 4'd7: rgb = {q, 8'hFF, 8'h00};
			4'd2, 4'd8: rgb = {8'h00, 8'hFF, t};
			4'd3:       rgb = {8'h00, q, 8'hFF};
			4'd4:       rgb = {t, 8'h00, 8'hFF};
			default:    rgb = {8'hFF, 8'h00, q};
		endcase
		return rgb;
	endfunction

	slfp_state_t state_q, state_d;

	logic [SPEED_W-1:0] speed_q;
	logic               sweep_q;
	logic [POS_W-1:0]   pos_q;
	logic               back_q;
	logic               bounce_q;
	logic [HUE_W-1:0]   hue_q;
	logic [COLOR_W-1:0] color_q;
	logic [COORD_W-1:0] line_cell_q;
	logic               line_hit_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;

	logic                      accept;
	logic                      step;
	logic                      at_last;
	logic signed [POS_W+1:0]   pos_ext;
	logic signed [POS_W+1:0]   sum;
	logic        [POS_W-1:0]   pos_new;
	logic signed [POS_W+1:0]   pos_new_ext;
	logic signed [POS_W+1:0]   edge_fix;
	logic                      bounce;
	logic        [7:0]         cell_whole;
	logic        [7:0]         edge_cells;
	logic                      hit_d;
	logic        [COORD_W-1:0] cell_d;

	assign accept  = in_valid && in_ready;
	assign step    = (state_q == ST_WALK) && step_ok;
	assign at_last = (x_q == X_LAST) && (y_q == Y_LAST);

	// move by the speed, saturate to 16 bits, test for a bounce
	always_comb begin
		pos_ext  = $signed({{2{pos_q[POS_W-1]}}, pos_q});
		sum      = back_q ? pos_ext - $signed({6'b0, speed_q})
		                  : pos_ext + $signed({6'b0, speed_q});
		if (sum > 18'sd32767) begin
			pos_new = 16'h7FFF;
		end else if (sum < -18'sd32768) begin
			pos_new = 16'h8000;
		end else begin
			pos_new = sum[POS_W-1:0];
		end
		pos_new_ext = $signed({{2{pos_new[POS_W-1]}}, pos_new});
		edge_fix    = sweep_q ? EDGE_W_FIX : EDGE_H_FIX;
		bounce      = (pos_new_ext >= edge_fix) || (pos_new_ext <= 18'sd0);
	end

	// line cell, position truncated toward zero
	always_comb begin
		cell_whole = {1'b0, pos_q[POS_W-2:8]};
		edge_cells = sweep_q ? 8'(GRID_WIDTH) : 8'(GRID_HEIGHT);
		if (!pos_q[POS_W-1]) begin
			hit_d  = cell_whole < edge_cells;
			cell_d = cell_whole[COORD_W-1:0];
		end else begin
			hit_d  = $signed(pos_q) > -16'sd256;
			cell_d = '0;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
			sweep_q <= 1'b1;
		end else if (cfg_valid) begin
			if (cfg_index == REG_LINE_SPEED) begin
				speed_q <= cfg_data[SPEED_W-1:0];
			end else if (cfg_index == REG_SWEEP_COLUMNS) begin
				sweep_q <= cfg_data[0];
			end
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			back_q      <= 1'b0;
			bounce_q    <= 1'b0;
			color_q     <= COLOR_RESET;
			line_cell_q <= '0;
			line_hit_q  <= 1'b0;
		end else begin
			if (accept) begin
				pos_q    <= pos_new;
				bounce_q <= bounce;
				if (bounce) back_q <= !back_q;
			end
			if (state_q == ST_COLOR) begin
				line_cell_q <= cell_d;
				line_hit_q  <= hit_d;
				if (bounce_q) color_q <= hue_to_rgb(hue_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) hue_q <= new_hue;
	end

	// walk counters, y fastest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (step) begin
			if (y_q == Y_LAST) begin
				y_q <= '0;
				x_q <= (x_q == X_LAST) ? '0 : x_q + 1'b1;
			end else begin
				y_q <= y_q + 1'b1;
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = pipe_empty;
				if (accept) state_d = ST_COLOR;
			end
			ST_COLOR: state_d = ST_WALK;
			ST_WALK: begin
				if (step && at_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign ctl.step    = step;
	assign ctl.x       = x_q;
	assign ctl.y       = y_q;
	assign ctl.last    = at_last;
	assign ctl.on_line = line_hit_q && (sweep_q ? (x_q == line_cell_q) : (y_q == line_cell_q));
	assign line_color  = color_q;

endmodule
`default_nettype wire

[sv/slfp_pixel.sv]
// Fade or line update of the head cell, then color scaling into the output
// register. Uses slfp_pkg.
`default_nettype none
module slfp_pixel (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire slfp_pkg::slfp_head_ctl_t      ctl,
	input  wire logic [slfp_pkg::LEVEL_W-1:0]  head_level,
	input  wire logic [slfp_pkg::COLOR_W-1:0]  line_color,
	output logic      [slfp_pkg::LEVEL_W-1:0]  new_level,
	output logic                              step_ok,
	output logic                              pipe_empty,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [slfp_pkg::COORD_W-1:0]  pixel_x,
	output logic      [slfp_pkg::COORD_W-1:0]  pixel_y,
	output logic      [slfp_pkg::COLOR_W-1:0]  pixel_color,
	output logic                              last_pixel
);
	import slfp_pkg::*;

	logic               valid_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic               last_s1;
	logic               out_valid_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [COLOR_W-1:0] color_q;
	logic               last_q;

	logic [LEVEL_W+7:0] fade_prod;
	logic [LEVEL_W-1:0] faded;
	logic               load_s2;
	logic [16:0]        r_prod;
	logic [16:0]        g_prod;
	logic [16:0]        b_prod;

	// fade, floor, or full on the line
	always_comb begin
		fade_prod = 17'(head_level) * 17'(FADE_MUL);
		faded     = fade_prod[LEVEL_W+7:8];
		if (ctl.on_line) begin
			new_level = LEVEL_FULL;
		end else if (faded < FADE_FLOOR) begin
			new_level = '0;
		end else begin
			new_level = faded;
		end
	end

	assign load_s2    = valid_s1 && (!out_valid_q || out_ready);
	assign step_ok    = !valid_s1 || load_s2;
	assign pipe_empty = !valid_s1;

	// stage 1: updated level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.step) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			level_s1 <= new_level;
			x_s1     <= ctl.x;
			y_s1     <= ctl.y;
			last_s1  <= ctl.last;
		end
	end

	// channel times level, >> 8
	assign r_prod = 17'(line_color[23:16]) * 17'(level_s1);
	assign g_prod = 17'(line_color[15:8]) * 17'(level_s1);
	assign b_prod = 17'(line_color[7:0]) * 17'(level_s1);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			x_q     <= x_s1;
			y_q     <= y_s1;
			last_q  <= last_s1;
			color_q <= {r_prod[15:8], g_prod[15:8], b_prod[15:8]};
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = x_q;
	assign pixel_y     = y_q;
	assign pixel_color = color_q;
	assign last_pixel  = last_q;

endmodule
`default_nettype wire

[sv/scan_line_fade_pattern.sv]
// Scan line fade pattern: one frame item in, GRID_WIDTH*GRID_HEIGHT pixel items out.
// Each frame item passes the color state, then stage 1 and the output register per pixel.
// A new frame item is taken only when idle with the pipeline empty; the cell chain
// rotates one cell a cycle while the output is not stalled by out_ready.
// Reset clears all cell levels, the line position and direction; color is red.
// Uses slfp_pkg, slfp_cell, slfp_line_ctrl, slfp_pixel.
`default_nettype none
module scan_line_fade_pattern #(
	parameter int GRID_WIDTH  = 8,
	parameter int GRID_HEIGHT = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [slfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [slfp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [slfp_pkg::HUE_W-1:0]      new_hue,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [slfp_pkg::COORD_W-1:0]    pixel_x,
	output logic      [slfp_pkg::COORD_W-1:0]    pixel_y,
	output logic      [slfp_pkg::COLOR_W-1:0]    pixel_color,
	output logic                                last_pixel
);
	import slfp_pkg::*;

	localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;

	slfp_head_ctl_t     ctl;
	logic [COLOR_W-1:0] line_color;
	logic [LEVEL_W-1:0] new_level;
	logic               step_ok;
	logic               pipe_empty;
	logic [LEVEL_W-1:0] level_chain [CELL_COUNT];

	assign cfg_ready = 1'b1;

	slfp_line_ctrl #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.new_hue    (new_hue),
		.pipe_empty (pipe_empty),
		.step_ok    (step_ok),
		.ctl        (ctl),
		.line_color (line_color)
	);

	// circulating chain: head is cell 0, updated level re-enters at the tail
	for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
		if (i == CELL_COUNT - 1) begin : g_tail
			slfp_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift     (ctl.step),
				.level_in  (new_level),
				.level_out (level_chain[i])
			);
		end else begin : g_body
			slfp_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift     (ctl.step),
				.level_in  (level_chain[i+1]),
				.level_out (level_chain[i])
			);
		end
	end

	slfp_pixel u_pixel (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.head_level  (level_chain[0]),
		.line_color  (line_color),
		.new_level   (new_level),
		.step_ok     (step_ok),
		.pipe_empty  (pipe_empty),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

`ifndef NO_ASSERTIONS
	// chain never steps while a new frame can be taken
	a_step_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> !in_ready) else $error("chain stepped while accepting");

	// the cycle after a frame item is the color cycle, no step
	a_no_step_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !ctl.step) else $error("step right after accept");

	// levels written back stay within full scale
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> (new_level <= LEVEL_FULL)) else $error("level above full");

	// last pixel flag only on the final grid position
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_pixel) |-> (pixel_x == COORD_W'(GRID_WIDTH - 1)
			&& pixel_y == COORD_W'(GRID_HEIGHT - 1))) else $error("last pixel misplaced");
`endif

endmodule
`default_nettype wire
